// ----- sv/mpmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpmc_pkg - shared types and constants of the multi-period move clock
// Item layouts, register map, period word fields and status codes.
// ----------------------------------------------------------------------------
package mpmc_pkg;

  localparam int MAX_PERIODS = 4;
  localparam int WORD_COUNT  = 4;
  localparam int PERIOD_LIMIT_INT = (MAX_PERIODS > WORD_COUNT) ? WORD_COUNT : MAX_PERIODS;
  localparam logic [2:0] PERIOD_LIMIT = 3'(PERIOD_LIMIT_INT);
  localparam int MS_PER_SEC = 1000;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_NUM_PERIODS = 3'd0;
  localparam logic [2:0] REG_WORD_0      = 3'd1;
  localparam logic [2:0] REG_WORD_1      = 3'd2;
  localparam logic [2:0] REG_WORD_2      = 3'd3;
  localparam logic [2:0] REG_WORD_3      = 3'd4;

  // commands
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_MOVE    = 1'b1;

  // period types
  localparam logic [3:0] KIND_ROLLOVER = 4'd1;
  localparam logic [3:0] KIND_GAME_IN  = 4'd2;
  localparam logic [3:0] KIND_MOVES_IN = 4'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXPIRED   = 2'd1;
  localparam logic [1:0] ST_BAD_TABLE = 2'd2;
  localparam logic [1:0] ST_NO_PERIOD = 2'd3;

  typedef struct packed {
    logic        command;
    logic [25:0] time_taken_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] time_left_ms;
    logic [7:0]  moves_left;
    logic [1:0]  period_now;
    logic        flag_out_of_time;
    logic [15:0] moves_played;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                       num_periods;
    logic [WORD_COUNT-1:0][31:0]      words;
  } cfg_t;

  function automatic logic [3:0] w_type(input logic [31:0] w);
    return w[31:28];
  endfunction

  function automatic logic [7:0] w_moves(input logic [31:0] w);
    return w[27:20];
  endfunction

  function automatic logic [15:0] w_secs(input logic [31:0] w);
    return w[19:4];
  endfunction

  function automatic logic [3:0] w_inc(input logic [31:0] w);
    return w[3:0];
  endfunction

  // moves left on entering a period
  function automatic logic [7:0] entry_moves(input logic [31:0] w);
    logic [7:0] m;
    case (w_type(w))
      KIND_ROLLOVER: m = w_moves(w);
      KIND_MOVES_IN: m = 8'd1;
      default:       m = 8'd0;
    endcase
    return m;
  endfunction

  function automatic logic period_ok(input logic [31:0] w);
    logic ok;
    case (w_type(w))
      KIND_ROLLOVER: ok = (w_moves(w) != 8'd0);
      KIND_GAME_IN:  ok = (w_moves(w) == 8'd0);
      KIND_MOVES_IN: ok = (w_moves(w) == 8'd1) && (w_inc(w) == 4'd0);
      default:       ok = 1'b0;
    endcase
    return ok && (w_secs(w) != 16'd0);
  endfunction

endpackage
`default_nettype wire

// ----- sv/mpmc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpmc_cfg_regs - configuration register file
// APB-style writes and reads of the period count and the four period words.
// ----------------------------------------------------------------------------
module mpmc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpmc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mpmc_pkg::DATA_W-1:0] pwdata,
  output logic      [mpmc_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output mpmc_pkg::cfg_t                   cfg
);
  import mpmc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_PERIODS: cfg_nxt.num_periods = pwdata[2:0];
        REG_WORD_0:      cfg_nxt.words[0]    = pwdata;
        REG_WORD_1:      cfg_nxt.words[1]    = pwdata;
        REG_WORD_2:      cfg_nxt.words[2]    = pwdata;
        REG_WORD_3:      cfg_nxt.words[3]    = pwdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_PERIODS: prdata = {29'd0, cfg_r.num_periods};
      REG_WORD_0:      prdata = cfg_r.words[0];
      REG_WORD_1:      prdata = cfg_r.words[1];
      REG_WORD_2:      prdata = cfg_r.words[2];
      REG_WORD_3:      prdata = cfg_r.words[3];
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_periods <= 3'd1;
      cfg_r.words       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- sv/mpmc_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpmc_update - clock state and single-pass item update
// Holds the clock state and computes the next state and result of one item.
// ----------------------------------------------------------------------------
module mpmc_update (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire mpmc_pkg::in_item_t   item,
  input  wire mpmc_pkg::cfg_t       cfg,
  output mpmc_pkg::out_item_t       result
);
  import mpmc_pkg::*;

  logic [1:0]  cur_period_r, cur_period_nxt;
  logic [31:0] remaining_r,  remaining_nxt;
  logic [7:0]  moves_left_r, moves_left_nxt;
  logic        expired_r,    expired_nxt;
  logic [15:0] move_total_r, move_total_nxt;
  logic [1:0]  status;

  logic [31:0] w_cur, w_nx, w_sel;
  logic [2:0]  nx;
  logic        cp_bad, nx_bad;
  logic        is_roll, enter;
  logic [7:0]  ml_dec;
  logic        over;
  logic        table_ok;
  logic [25:0] secs_ms;
  logic [13:0] inc_ms;
  logic [33:0] acc;
  logic [31:0] acc_sat;

  assign w_cur   = cfg.words[cur_period_r];
  assign w_nx    = cfg.words[cur_period_r + 2'd1];
  assign nx      = {1'b0, cur_period_r} + 3'd1;
  assign cp_bad  = ({1'b0, cur_period_r} >= cfg.num_periods) ||
                   ({1'b0, cur_period_r} >= PERIOD_LIMIT);
  assign nx_bad  = (nx >= cfg.num_periods) || (nx >= PERIOD_LIMIT);
  assign is_roll = (w_type(w_cur) == KIND_ROLLOVER);
  assign ml_dec  = moves_left_r - 8'd1;
  assign enter   = is_roll && (ml_dec == 8'd0) && !nx_bad;
  assign over    = remaining_r < {6'd0, item.time_taken_ms};

  // shared seconds-to-ms multiplier, operand picked by what the item needs
  always_comb begin
    if (item.command == CMD_RESTART) w_sel = cfg.words[0];
    else if (enter)                  w_sel = w_nx;
    else                             w_sel = w_cur;
  end
  assign secs_ms = 26'(w_secs(w_sel)) * 26'(MS_PER_SEC);
  assign inc_ms  = 14'(w_inc(w_cur)) * 14'(MS_PER_SEC);

  // both additions saturate at the top; clamping once at the end is the same
  assign acc = {2'd0, remaining_r} - {8'd0, item.time_taken_ms} + {20'd0, inc_ms}
             + (enter ? {8'd0, secs_ms} : 34'd0);
  assign acc_sat = (acc[33:32] != 2'd0) ? '1 : acc[31:0];

  always_comb begin
    logic ok;
    ok = (cfg.num_periods != 3'd0) && (cfg.num_periods <= PERIOD_LIMIT);
    for (int i = 0; i < WORD_COUNT; i++) begin
      if (3'(i) < cfg.num_periods) begin
        if (!period_ok(cfg.words[i])) ok = 1'b0;
        if ((3'(i) + 3'd1 < cfg.num_periods) &&
            (w_type(cfg.words[i]) != KIND_ROLLOVER))
          ok = 1'b0;
        if ((3'(i) + 3'd1 == cfg.num_periods) &&
            (w_type(cfg.words[i]) == KIND_ROLLOVER))
          ok = 1'b0;
      end
    end
    table_ok = ok;
  end

  always_comb begin
    cur_period_nxt = cur_period_r;
    remaining_nxt  = remaining_r;
    moves_left_nxt = moves_left_r;
    expired_nxt    = expired_r;
    move_total_nxt = move_total_r;
    status         = ST_OK;
    if (item.command == CMD_RESTART) begin
      if (table_ok) begin
        cur_period_nxt = 2'd0;
        expired_nxt    = 1'b0;
        remaining_nxt  = {6'd0, secs_ms};
        moves_left_nxt = entry_moves(cfg.words[0]);
      end else begin
        status = ST_BAD_TABLE;
      end
    end else if (expired_r) begin
      status = ST_EXPIRED;
    end else if (cp_bad) begin
      status = ST_NO_PERIOD;
    end else begin
      move_total_nxt = move_total_r + 16'd1;
      if (over) begin
        remaining_nxt = '0;
        expired_nxt   = 1'b1;
      end else begin
        remaining_nxt = acc_sat;
        if (is_roll) begin
          moves_left_nxt = ml_dec;
          if (ml_dec == 8'd0) begin
            if (nx_bad) begin
              status = ST_NO_PERIOD;
            end else begin
              cur_period_nxt = nx[1:0];
              moves_left_nxt = entry_moves(w_nx);
            end
          end
        end else if (w_type(w_cur) == KIND_MOVES_IN) begin
          remaining_nxt = {6'd0, secs_ms};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_period_r <= '0;
      remaining_r  <= '0;
      moves_left_r <= '0;
      expired_r    <= 1'b0;
      move_total_r <= '0;
    end else if (fire) begin
      cur_period_r <= cur_period_nxt;
      remaining_r  <= remaining_nxt;
      moves_left_r <= moves_left_nxt;
      expired_r    <= expired_nxt;
      move_total_r <= move_total_nxt;
    end
  end

  assign result.status           = status;
  assign result.time_left_ms     = remaining_nxt;
  assign result.moves_left       = moves_left_nxt;
  assign result.period_now       = cur_period_nxt;
  assign result.flag_out_of_time = expired_nxt;
  assign result.moves_played     = move_total_nxt;

endmodule
`default_nettype wire

// ----- sv/multi_period_move_clock.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_period_move_clock - one-player move clock over up to four periods
// Restart and move items update remaining time, period and move counts
// with Fischer increment; one result item per input item.
// ----------------------------------------------------------------------------
//   port group  | direction | handshake          | payload
//   in_*        | input     | in_valid/in_stall  | in_data   (command, time)
//   out_*       | output    | out_valid/out_stall| out_data  (status, state)
//   APB config  | input     | psel/penable/pready| paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall is low; items pass the input
// register, then the result register, with a single-pass update between.
// rst_n is synchronous: state clears, num_periods goes to 1, words to 0.
// A held out_stall freezes a full result register; the input register keeps
// its item and in_stall rises only while both registers are full.
// ----------------------------------------------------------------------------
module multi_period_move_clock (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // item input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mpmc_pkg::in_item_t          in_data,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mpmc_pkg::out_item_t              out_data,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpmc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mpmc_pkg::DATA_W-1:0] pwdata,
  output logic      [mpmc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import mpmc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_vld_r, out_vld_nxt;
  logic      adv_out;   // result register may load this cycle
  logic      fire;      // held item is processed and moves to the result
  logic      in_take;

  mpmc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpmc_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // handshake: the result register drains or is empty -> pipeline moves
  assign adv_out  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv_out;
  assign in_stall = in_vld_r && !adv_out;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take)   in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv_out) out_vld_nxt = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) in_item_r  <= in_data;
    if (fire)    out_item_r <= result;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ----- sim/multi_period_move_clock_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_period_move_clock_test - self-checking bench for the move clock
// A short directed run covers the corner cases: bad tables, out of time,
// a rollover end with no next period, the moves count wrapping, unknown
// period types and live edits. It is followed by random restart and move
// items over many random period tables. A scoreboard works out each result
// and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module multi_period_move_clock_test;
  import mpmc_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the registers and the clock state,
  // predicts one result per accepted item and checks results in order.
  // --------------------------------------------------------------------------
  class clock_board;
    logic [2:0]  n_periods;
    logic [31:0] words [4];
    logic [1:0]  period;
    logic [31:0] remain;
    logic [7:0]  moves_left;
    logic        expired;
    logic [15:0] played;
    out_item_t   due_results [$];
    int          errors;
    int          checked;
    int          status_seen [4];

    function new();
      n_periods = 3'd1;
      foreach (words[i]) words[i] = '0;
      period     = '0;
      remain     = '0;
      moves_left = '0;
      expired    = 1'b0;
      played     = '0;
      errors     = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_NUM_PERIODS: n_periods = val[2:0];
        REG_WORD_0:      words[0]  = val;
        REG_WORD_1:      words[1]  = val;
        REG_WORD_2:      words[2]  = val;
        REG_WORD_3:      words[3]  = val;
        default:         ;
      endcase
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function logic [31:0] secs_ms(logic [15:0] s);
      return 32'(s) * 32'(MS_PER_SEC);
    endfunction

    function bit word_valid(logic [31:0] w);
      if (w[19:4] == 16'd0) return 1'b0;
      case (w[31:28])
        KIND_ROLLOVER: return w[27:20] != 8'd0;
        KIND_GAME_IN:  return w[27:20] == 8'd0;
        KIND_MOVES_IN: return (w[27:20] == 8'd1) && (w[3:0] == 4'd0);
        default:       return 1'b0;
      endcase
    endfunction

    function bit table_valid();
      int i;
      if (n_periods == 3'd0 || n_periods > PERIOD_LIMIT) return 1'b0;
      for (i = 0; i < int'(n_periods); i++) begin
        if (!word_valid(words[i])) return 1'b0;
        if (i + 1 < int'(n_periods) && words[i][31:28] != KIND_ROLLOVER) return 1'b0;
        if (i + 1 == int'(n_periods) && words[i][31:28] == KIND_ROLLOVER) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void enter(logic [31:0] w);
      remain = add_sat(remain, secs_ms(w[19:4]));
      case (w[31:28])
        KIND_ROLLOVER: moves_left = w[27:20];
        KIND_MOVES_IN: moves_left = 8'd1;
        default:       moves_left = 8'd0;
      endcase
    endfunction

    function logic [1:0] do_move(logic [31:0] taken);
      logic [31:0] w;
      logic [2:0]  nx;
      if (expired) return ST_EXPIRED;
      if ({1'b0, period} >= n_periods || {1'b0, period} >= PERIOD_LIMIT) return ST_NO_PERIOD;
      w      = words[period];
      played = played + 16'd1;
      if (remain < taken) begin
        remain  = '0;
        expired = 1'b1;
        return ST_OK;
      end
      remain = add_sat(remain - taken, secs_ms({12'd0, w[3:0]}));
      if (w[31:28] == KIND_ROLLOVER) begin
        moves_left = moves_left - 8'd1;
        if (moves_left == 8'd0) begin
          nx = {1'b0, period} + 3'd1;
          if (nx >= n_periods || nx >= PERIOD_LIMIT) return ST_NO_PERIOD;
          period = nx[1:0];
          enter(words[period]);
        end
      end else if (w[31:28] == KIND_MOVES_IN) begin
        remain = secs_ms(w[19:4]);
      end
      return ST_OK;
    endfunction

    function void note_item(in_item_t it);
      out_item_t  e;
      logic [1:0] st;
      if (it.command == CMD_RESTART) begin
        if (table_valid()) begin
          period     = '0;
          expired    = 1'b0;
          remain     = '0;
          moves_left = '0;
          enter(words[0]);
          st = ST_OK;
        end else begin
          st = ST_BAD_TABLE;
        end
      end else begin
        st = do_move(32'(it.time_taken_ms));
      end
      e.status           = st;
      e.time_left_ms     = remain;
      e.moves_left       = moves_left;
      e.period_now       = period;
      e.flag_out_of_time = expired;
      e.moves_played     = played;
      due_results = {due_results, e};
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, seen);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_results.size() == 0) begin
        $display("%0t ns: result %h with nothing expected", $time, got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      checked++;
      status_seen[e.status]++;
      if (got.status !== e.status)
        report("status", 32'(e.status), 32'(got.status));
      if (got.time_left_ms !== e.time_left_ms)
        report("time_left_ms", e.time_left_ms, got.time_left_ms);
      if (got.moves_left !== e.moves_left)
        report("moves_left", 32'(e.moves_left), 32'(got.moves_left));
      if (got.period_now !== e.period_now)
        report("period_now", 32'(e.period_now), 32'(got.period_now));
      if (got.flag_out_of_time !== e.flag_out_of_time)
        report("flag_out_of_time", 32'(e.flag_out_of_time), 32'(got.flag_out_of_time));
      if (got.moves_played !== e.moves_played)
        report("moves_played", 32'(e.moves_played), 32'(got.moves_played));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every block input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  clock_board board = new();

  // no-idle stretches for the sender and the receiver, set per phase
  bit quiet_send = 1'b0;
  bit quiet_sink = 1'b0;
  int sent       = 0;
  int tables     = 0;

  multi_period_move_clock u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: a stop set well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still due", board.due_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. Everything is sampled right after the rising edge, before
  // the block's nonblocking updates land, so the values seen are the ones
  // the edge acted on. After each result a random stall is drawn; twice in
  // the run the receiver holds off for a long stretch so that both
  // registers of the block fill and in_stall rises while items keep coming.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_result(out_data);
        stall_left = quiet_sink ? 0 : $urandom_range(0, 19);
        if (board.checked == 150 || board.checked == 700) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. in_valid stays high after an accepted item until the next
  // call decides: a zero gap just swaps the payload, so valid never drops
  // and rises in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    sent++;
  endtask

  task automatic restart(input logic [25:0] junk);
    send_item({CMD_RESTART, junk});
  endtask

  task automatic move(input logic [25:0] ms);
    send_item({CMD_MOVE, ms});
  endtask

  // drop valid and let every expected result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_table(input logic [2:0] n, input logic [3:0][31:0] w);
    wait_idle();
    reg_write(REG_NUM_PERIODS, {29'd0, n});
    reg_write(REG_WORD_0, w[0]);
    reg_write(REG_WORD_1, w[1]);
    reg_write(REG_WORD_2, w[2]);
    reg_write(REG_WORD_3, w[3]);
    tables++;
  endtask

  function automatic logic [31:0] pword(logic [3:0] kind, logic [7:0] mv, logic [15:0] secs,
                                        logic [3:0] inc);
    return {kind, mv, secs, inc};
  endfunction

  // Random table: mostly valid (rollovers then a game-in or moves-in end),
  // short rollover counts so later periods are reached; now and then one
  // field is broken. Slots past the end get random junk.
  task automatic random_table(output logic [2:0] n, output logic [3:0][31:0] w);
    int         k;
    logic [7:0] mv;
    logic [15:0] secs;
    n = 3'($urandom_range(1, 4));
    for (k = 0; k < 4; k++) begin
      mv   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 4));
      secs = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 20));
      if (k + 1 < int'(n))
        w[k] = pword(KIND_ROLLOVER, mv, secs, 4'($urandom_range(0, 15)));
      else if (k + 1 == int'(n))
        w[k] = $urandom_range(0, 1) ? pword(KIND_GAME_IN, 8'd0, secs, 4'($urandom_range(0, 15)))
                                    : pword(KIND_MOVES_IN, 8'd1, secs, 4'd0);
      else
        w[k] = $urandom();
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0:       n = 3'($urandom_range(0, 7));
        1:       w[k] = $urandom();
        2:       w[k][31:28] = 4'($urandom_range(0, 15));
        default: w[k][19:4] = 16'd0;
      endcase
    end
  endtask

  // Next random item, shaped by the predicted state: most moves fit in the
  // time left, some hit it exactly or by one, some are wild 26-bit values.
  function automatic in_item_t pick_item();
    in_item_t    it;
    logic [31:0] cap;
    int          r;
    cap = (board.remain > 32'h03FF_FFFF) ? 32'h03FF_FFFF : board.remain;
    r   = $urandom_range(0, 99);
    it.command = CMD_MOVE;
    if ((board.expired && r < 50) || r < 4) begin
      it.command       = CMD_RESTART;
      it.time_taken_ms = 26'($urandom());
    end else if (r < 55) begin
      it.time_taken_ms = 26'($urandom_range(0, cap));
    end else if (r < 75) begin
      it.time_taken_ms = 26'($urandom_range(0, 3000));
    end else if (r < 85) begin
      it.time_taken_ms = 26'(cap + $urandom_range(0, 1));
    end else begin
      it.time_taken_ms = 26'($urandom());
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [2:0]        n;
    logic [3:0][31:0]  w;
    int                rand_items;
    int                len;
    logic [31:0]       ok_roll;
    logic [31:0]       ok_game;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset table: one period of type none. A zero-time move only applies
    // time and increment, any later time runs out, then moves are refused;
    // the restart sees seconds zero and reports a bad table.
    move(26'd0);
    move(26'h3FF_FFFF);
    move(26'd5);
    restart(26'd0);

    // Four periods with the field extremes; walk through period changes,
    // then run out on the largest time field and restart.
    load_table(3'd4, {pword(KIND_GAME_IN, 8'd0, 16'd100, 4'd3),
                      pword(KIND_ROLLOVER, 8'd255, 16'd2, 4'd1),
                      pword(KIND_ROLLOVER, 8'd1, 16'hFFFF, 4'd0),
                      pword(KIND_ROLLOVER, 8'd2, 16'd1, 4'd15)});
    restart(26'h3FF_FFFF);
    move(26'd0);
    move(26'd16000);
    move(26'd1);
    move(26'h3FF_FFFF);
    restart(26'd0);

    // moves-in: full reload after each move, then out of time by one ms
    load_table(3'd1, {96'd0, pword(KIND_MOVES_IN, 8'd1, 16'd3, 4'd0)});
    restart(26'd0);
    move(26'd2999);
    move(26'd3001);

    // bad tables: count too big or zero, game-in not last, rollover last,
    // moves-in with increment or wrong count, unknown and none types,
    // zero seconds
    ok_roll = pword(KIND_ROLLOVER, 8'd3, 16'd5, 4'd1);
    ok_game = pword(KIND_GAME_IN, 8'd0, 16'd9, 4'd2);
    load_table(3'd5, {ok_game, ok_roll, ok_roll, ok_roll});
    restart(26'd0);
    load_table(3'd0, {96'd0, ok_game});
    restart(26'd0);
    load_table(3'd2, {64'd0, ok_game, ok_game});
    restart(26'd0);
    load_table(3'd2, {64'd0, ok_roll, ok_roll});
    restart(26'd0);
    load_table(3'd1, {96'd0, pword(KIND_MOVES_IN, 8'd1, 16'd3, 4'd1)});
    restart(26'd0);
    load_table(3'd1, {96'd0, pword(KIND_MOVES_IN, 8'd2, 16'd3, 4'd0)});
    restart(26'd0);
    load_table(3'd1, {96'd0, pword(4'hF, 8'd0, 16'd5, 4'd0)});
    restart(26'd0);
    load_table(3'd1, {96'd0, pword(4'h0, 8'd0, 16'd5, 4'd0)});
    restart(26'd0);
    load_table(3'd1, {96'd0, pword(KIND_GAME_IN, 8'd0, 16'd0, 4'd0)});
    restart(26'd0);

    // Live edits after a good restart: shrink to one period so the
    // rollover ends with no next period, then the count wraps; with zero
    // periods a move finds no current period.
    load_table(3'd2, {64'd0, ok_game, pword(KIND_ROLLOVER, 8'd1, 16'd5, 4'd2)});
    restart(26'd0);
    wait_idle();
    reg_write(REG_NUM_PERIODS, 32'd1);
    move(26'd100);
    move(26'd100);
    wait_idle();
    reg_write(REG_NUM_PERIODS, 32'd0);
    move(26'd0);

    // entering a period whose word turned unknown, then moving in it
    load_table(3'd2, {64'd0, ok_game, pword(KIND_ROLLOVER, 8'd1, 16'd5, 4'd2)});
    restart(26'd0);
    wait_idle();
    reg_write(REG_WORD_1, pword(4'd9, 8'd0, 16'd7, 4'd4));
    move(26'd0);
    move(26'd10);

    // Random phases: a fresh table each time, usually a restart first (the
    // rest keep the old state under the new table), with no-idle stretches
    // on either side now and then.
    rand_items = 0;
    while (rand_items < 1000) begin
      random_table(n, w);
      load_table(n, w);
      quiet_send = ($urandom_range(0, 4) == 0);
      quiet_sink = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        restart(26'($urandom()));
        rand_items++;
      end
      len = $urandom_range(10, 60);
      repeat (len) begin
        send_item(pick_item());
        rand_items++;
      end
    end

    // drain, then idle on for anything stray
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Run covered %0d items over %0d register loads, %0d results checked",
             sent, tables, board.checked);
    $display("Results by status: ok %0d, out of time %0d, bad table %0d, no period %0d",
             board.status_seen[ST_OK], board.status_seen[ST_EXPIRED],
             board.status_seen[ST_BAD_TABLE], board.status_seen[ST_NO_PERIOD]);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
